// ===== design/jtag_tap_state_navigator_defines.svh =====
// Assertion macros used by the TAP navigator top level.
`ifndef JTAG_TAP_STATE_NAVIGATOR_DEFINES_SVH
`define JTAG_TAP_STATE_NAVIGATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JTSN_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define JTSN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/jtsn_pkg.sv =====
// Types, constants and TAP transition functions for the TAP navigator.
`default_nettype none
package jtsn_pkg;

    localparam logic [1:0] ACT_GOTO  = 2'd0;
    localparam logic [1:0] ACT_RESET = 2'd1;
    localparam logic [1:0] ACT_IDLE  = 2'd2;

    localparam logic [3:0] TAP_TLR    = 4'd0;
    localparam logic [3:0] TAP_RTI    = 4'd1;
    localparam logic [3:0] TAP_SEL_DR = 4'd2;
    localparam logic [3:0] TAP_SEL_IR = 4'd9;

    // Offsets of the column states relative to the DR column numbering.
    localparam logic [3:0] REL_CAPTURE = 4'd3;
    localparam logic [3:0] REL_SHIFT   = 4'd4;
    localparam logic [3:0] REL_EXIT1   = 4'd5;
    localparam logic [3:0] REL_PAUSE   = 4'd6;
    localparam logic [3:0] REL_EXIT2   = 4'd7;
    localparam logic [3:0] REL_UPDATE  = 4'd8;
    localparam logic [3:0] IR_OFFSET   = 4'd7;

    localparam logic [5:0] MAX_RUN   = 6'd32;
    localparam logic [5:0] RESET_RUN = 6'd6;

    localparam logic [3:0] NEXT_ON0 [16] = '{
        4'd1, 4'd1, 4'd3, 4'd4, 4'd4, 4'd6, 4'd6, 4'd4,
        4'd1, 4'd10, 4'd11, 4'd11, 4'd13, 4'd13, 4'd11, 4'd1
    };
    localparam logic [3:0] NEXT_ON1 [16] = '{
        4'd0, 4'd2, 4'd9, 4'd5, 4'd5, 4'd8, 4'd7, 4'd8,
        4'd2, 4'd0, 4'd12, 4'd12, 4'd15, 4'd14, 4'd15, 4'd2
    };

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] target_state;
        logic [5:0] clock_count;
    } cmd_item_t;

    typedef struct packed {
        logic       tms_bit;
        logic [3:0] tap_after;
        logic       last;
    } bit_item_t;

    typedef struct packed {
        logic load;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic can_step;
        logic step_last;
    } dp_status_t;

    function automatic logic [3:0] tap_advance(logic [3:0] pos, logic tms);
        logic [3:0] nxt;
        nxt = tms ? NEXT_ON1[pos] : NEXT_ON0[pos];
        return nxt;
    endfunction

    // TMS level for one routing step from pos toward target, pos differing from target.
    function automatic logic route_bit(logic [3:0] pos, logic [3:0] target);
        logic [3:0] base;
        logic [3:0] rel;
        logic [3:0] trel;
        logic       same_col;
        logic       r;
        base     = (pos >= 4'd10) ? IR_OFFSET : 4'd0;
        rel      = pos - base;
        same_col = (target >= REL_CAPTURE + base) && (target <= REL_UPDATE + base);
        trel     = same_col ? target - base : 4'd0;
        priority if (pos == TAP_TLR)
            r = 1'b0;
        else if (pos == TAP_RTI)
            r = 1'b1;
        else if (pos == TAP_SEL_DR)
            r = !((target >= REL_CAPTURE) && (target <= REL_UPDATE));
        else if (pos == TAP_SEL_IR)
            r = !(target >= REL_CAPTURE + IR_OFFSET);
        else if (rel == REL_CAPTURE)
            r = (trel != REL_SHIFT);
        else if (rel == REL_EXIT1)
            r = !((trel >= REL_SHIFT) && (trel <= REL_EXIT2));
        else if (rel == REL_EXIT2)
            r = !((trel >= REL_SHIFT) && (trel <= REL_PAUSE));
        else if (rel == REL_UPDATE)
            r = (target != TAP_RTI);
        else
            r = 1'b1;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/jtag_tap_state_navigator.sv =====
// Top level of the JTAG TAP state navigator.
// Tracks the TAP controller position (run-test-idle after reset) and turns each command
// item into a run of TMS bits, one bit item per clock while bit_stall is low: a goto walks
// the routing rules to the target in 0 to 32 bits (typically about six), a reset gives six
// ones, and an idle gives its clock count of bits, capped at 32. One command is worked at a
// time; one that gives bits is loaded and then stepped, paced by the single TMS stepping
// unit and by the output register, and one that gives none is taken without a run. The
// next command is taken while the final bit still waits in the output register.
`default_nettype none
module jtag_tap_state_navigator (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    input  wire jtsn_pkg::cmd_item_t cmd_item,
    output logic                     bit_valid,
    input  wire logic                bit_stall,
    output jtsn_pkg::bit_item_t      bit_item
);
    import jtsn_pkg::*;
    `include "jtag_tap_state_navigator_defines.svh"

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    jtsn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    jtsn_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_item  (cmd_item),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .bit_valid (bit_valid),
        .bit_stall (bit_stall),
        .bit_item  (bit_item)
    );

    `JTSN_ASSERT_SAME(a_load_step_excl, dp_cmd.load, !dp_cmd.step, "load and step together")
    `JTSN_ASSERT_SAME(a_step_room, dp_cmd.step, dp_status.can_step, "step into a full output")
    `JTSN_ASSERT_NEXT(a_busy_after_load, dp_cmd.load && !dp_status.empty, cmd_stall,
                      "command taken while a run is in progress")

endmodule
`default_nettype wire

// ===== design/jtsn_ctrl.sv =====
// Controller state machine that sequences loading and stepping of the TAP datapath.
`default_nettype none
module jtsn_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    input  wire jtsn_pkg::dp_status_t status,
    output jtsn_pkg::dp_cmd_t        cmd
);
    import jtsn_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd.load  = (state_reg == ST_IDLE) && cmd_valid;
    assign cmd.step  = (state_reg == ST_RUN) && status.can_step;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !status.empty)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (status.can_step && status.step_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// ===== design/jtsn_datapath.sv =====
// Datapath holding the TAP position, the run counter and the output register.
`default_nettype none
module jtsn_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire jtsn_pkg::cmd_item_t  cmd_item,
    input  wire jtsn_pkg::dp_cmd_t    cmd,
    output jtsn_pkg::dp_status_t      status,
    output logic                      bit_valid,
    input  wire logic                 bit_stall,
    output jtsn_pkg::bit_item_t       bit_item
);
    import jtsn_pkg::*;

    logic [3:0] pos_reg,    pos_next;
    logic [3:0] target_reg, target_next;
    logic [1:0] mode_reg,   mode_next;
    logic       idle_tms_reg, idle_tms_next;
    logic [5:0] cnt_reg,    cnt_next;
    logic [5:0] limit_reg,  limit_next;
    logic       out_valid_reg, out_valid_next;
    bit_item_t  out_reg,    out_next;

    logic       step_tms;
    logic [3:0] step_pos;
    logic [5:0] cnt_inc;
    logic [5:0] idle_limit;

    assign idle_limit = (cmd_item.clock_count > MAX_RUN) ? MAX_RUN : cmd_item.clock_count;

    always_comb
    begin
        unique case (mode_reg)
            ACT_GOTO:  step_tms = route_bit(pos_reg, target_reg);
            ACT_RESET: step_tms = 1'b1;
            default:   step_tms = idle_tms_reg;
        endcase
    end

    assign step_pos = tap_advance(pos_reg, step_tms);
    assign cnt_inc  = cnt_reg + 6'd1;

    assign status.can_step  = !out_valid_reg || !bit_stall;
    assign status.step_last = (cnt_inc == limit_reg)
                              || ((mode_reg == ACT_GOTO) && (step_pos == target_reg));
    // An item causes no bits when the goto target is already reached, the idle
    // count is zero, or the action code is unused.
    assign status.empty = ((cmd_item.action == ACT_GOTO) && (cmd_item.target_state == pos_reg))
                          || ((cmd_item.action == ACT_IDLE) && (cmd_item.clock_count == 6'd0))
                          || ((cmd_item.action != ACT_GOTO) && (cmd_item.action != ACT_RESET)
                              && (cmd_item.action != ACT_IDLE));

    always_comb
    begin
        pos_next      = pos_reg;
        target_next   = target_reg;
        mode_next     = mode_reg;
        idle_tms_next = idle_tms_reg;
        cnt_next      = cnt_reg;
        limit_next    = limit_reg;
        out_next      = out_reg;
        out_valid_next = out_valid_reg && bit_stall;
        if (cmd.load)
        begin
            target_next   = cmd_item.target_state;
            mode_next     = cmd_item.action;
            idle_tms_next = (pos_reg == TAP_TLR);
            cnt_next      = 6'd0;
            if (cmd_item.action == ACT_GOTO)
                limit_next = MAX_RUN;
            else if (cmd_item.action == ACT_RESET)
                limit_next = RESET_RUN;
            else
                limit_next = idle_limit;
        end
        if (cmd.step)
        begin
            pos_next           = step_pos;
            cnt_next           = cnt_inc;
            out_next.tms_bit   = step_tms;
            out_next.tap_after = step_pos;
            out_next.last      = status.step_last;
            out_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= TAP_RTI;
            out_valid_reg <= 1'b0;
            mode_reg      <= ACT_GOTO;
            cnt_reg       <= 6'd0;
            limit_reg     <= MAX_RUN;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
            limit_reg     <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg   <= target_next;
        idle_tms_reg <= idle_tms_next;
        out_reg      <= out_next;
    end

    assign bit_valid = out_valid_reg;
    assign bit_item  = out_reg;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the JTAG TAP state navigator: directed table, random commands, stalls.
`timescale 1ns / 1ps
module tb;
    import jtsn_pkg::*;

    typedef enum logic [3:0] {
        ST_TLR, ST_RTI,
        ST_SEL_DR, ST_CAP_DR, ST_SHIFT_DR, ST_EXIT1_DR, ST_PAUSE_DR, ST_EXIT2_DR, ST_UPD_DR,
        ST_SEL_IR, ST_CAP_IR, ST_SHIFT_IR, ST_EXIT1_IR, ST_PAUSE_IR, ST_EXIT2_IR, ST_UPD_IR
    } tap_state_t;

    // Action code that the block ignores.
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int unsigned NUM_DIRECTED = 26;
    localparam int unsigned RANDOM_ITEMS = 440;
    localparam int unsigned DRAIN_CYCLES = 64;

    // A row of stimulus; when typed is set, the expected run is written out in the row:
    // runlen bits all at level tms, with the states after each bit in taps, first in the top nibble.
    typedef struct packed {
        cmd_item_t   cmd;
        logic        typed;
        logic [2:0]  runlen;
        logic        tms;
        logic [23:0] taps;
    } step_row_t;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_item_t cmd_item;
    logic      bit_valid;
    logic      bit_stall;
    bit_item_t bit_item;

    tap_state_t  tap_now;
    bit_item_t   run_bits [$];
    bit_item_t   expected_bits [$];
    step_row_t   cmds_in_flight [$];
    step_row_t   script [NUM_DIRECTED];
    int unsigned idle_pct;
    int unsigned cmds_taken;
    int unsigned bits_checked;
    int unsigned mismatches;

    jtag_tap_state_navigator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .bit_valid (bit_valid),
        .bit_stall (bit_stall),
        .bit_item  (bit_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic tap_state_t tap_next(tap_state_t s, logic tms);
        case (s)
            ST_TLR:      return tms ? ST_TLR : ST_RTI;
            ST_RTI:      return tms ? ST_SEL_DR : ST_RTI;
            ST_SEL_DR:   return tms ? ST_SEL_IR : ST_CAP_DR;
            ST_CAP_DR:   return tms ? ST_EXIT1_DR : ST_SHIFT_DR;
            ST_SHIFT_DR: return tms ? ST_EXIT1_DR : ST_SHIFT_DR;
            ST_EXIT1_DR: return tms ? ST_UPD_DR : ST_PAUSE_DR;
            ST_PAUSE_DR: return tms ? ST_EXIT2_DR : ST_PAUSE_DR;
            ST_EXIT2_DR: return tms ? ST_UPD_DR : ST_SHIFT_DR;
            ST_UPD_DR:   return tms ? ST_SEL_DR : ST_RTI;
            ST_SEL_IR:   return tms ? ST_TLR : ST_CAP_IR;
            ST_CAP_IR:   return tms ? ST_EXIT1_IR : ST_SHIFT_IR;
            ST_SHIFT_IR: return tms ? ST_EXIT1_IR : ST_SHIFT_IR;
            ST_EXIT1_IR: return tms ? ST_UPD_IR : ST_PAUSE_IR;
            ST_PAUSE_IR: return tms ? ST_EXIT2_IR : ST_PAUSE_IR;
            ST_EXIT2_IR: return tms ? ST_UPD_IR : ST_SHIFT_IR;
            ST_UPD_IR:   return tms ? ST_SEL_DR : ST_RTI;
            default:     return ST_TLR;
        endcase
    endfunction

    function automatic logic route_tms(tap_state_t at, tap_state_t goal);
        logic       goal_dr;
        logic       goal_ir;
        logic       ir_side;
        logic [3:0] off;
        logic [3:0] at_rel;
        logic [3:0] goal_rel;
        goal_dr  = (goal >= ST_CAP_DR) && (goal <= ST_UPD_DR);
        goal_ir  = (goal >= ST_CAP_IR);
        ir_side  = (at >= ST_CAP_IR);
        off      = ir_side ? IR_OFFSET : 4'd0;
        at_rel   = at - off;
        // A goal outside the current column is treated as no column position at all.
        goal_rel = (ir_side ? goal_ir : goal_dr) ? goal - off : 4'd0;
        case (at)
            ST_TLR:    return 1'b0;
            ST_RTI:    return 1'b1;
            ST_SEL_DR: return !goal_dr;
            ST_SEL_IR: return !goal_ir;
            default:   ;
        endcase
        if (at_rel == REL_CAPTURE)
            return goal_rel != REL_SHIFT;
        if (at_rel == REL_EXIT1)
            return !((goal_rel >= REL_SHIFT) && (goal_rel <= REL_EXIT2));
        if (at_rel == REL_EXIT2)
            return !((goal_rel >= REL_SHIFT) && (goal_rel <= REL_PAUSE));
        if (at_rel == REL_UPDATE)
            return goal != ST_RTI;
        return 1'b1;
    endfunction

    // Works out the TMS run of one command and moves the tracked TAP position.
    function automatic void predict_run(cmd_item_t c);
        tap_state_t  at;
        tap_state_t  goal;
        logic        tms;
        int unsigned cnt;
        at   = tap_now;
        goal = tap_state_t'(c.target_state);
        run_bits.delete();
        case (c.action)
            ACT_GOTO:
            begin
                while (at != goal && run_bits.size() < int'(MAX_RUN))
                begin
                    tms = route_tms(at, goal);
                    at  = tap_next(at, tms);
                    run_bits.push_back('{tms_bit: tms, tap_after: at, last: 1'b0});
                end
            end
            ACT_RESET:
            begin
                repeat (int'(RESET_RUN))
                begin
                    at = tap_next(at, 1'b1);
                    run_bits.push_back('{tms_bit: 1'b1, tap_after: at, last: 1'b0});
                end
            end
            ACT_IDLE:
            begin
                cnt = (c.clock_count > MAX_RUN) ? int'(MAX_RUN) : int'(c.clock_count);
                tms = (at == ST_TLR);
                repeat (cnt)
                begin
                    at = tap_next(at, tms);
                    run_bits.push_back('{tms_bit: tms, tap_after: at, last: 1'b0});
                end
            end
            default: ;
        endcase
        if (run_bits.size() != 0)
            run_bits[run_bits.size() - 1].last = 1'b1;
        tap_now = at;
    endfunction

    function automatic step_row_t row_of(logic [1:0] act, logic [3:0] tgt, logic [5:0] cnt,
                                         logic typed, logic [2:0] n, logic tms,
                                         logic [23:0] taps);
        step_row_t r;
        r.cmd    = '{action: act, target_state: tgt, clock_count: cnt};
        r.typed  = typed;
        r.runlen = n;
        r.tms    = tms;
        r.taps   = taps;
        return r;
    endfunction

    function automatic step_row_t random_row();
        int unsigned pick;
        step_row_t   r;
        pick = $urandom_range(0, 99);
        r    = row_of(ACT_GOTO, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                      1'b0, 3'd0, 1'b0, 24'h0);
        if (pick >= 55 && pick < 65)
            r.cmd.action = ACT_RESET;
        else if (pick >= 65 && pick < 95)
        begin
            r.cmd.action = ACT_IDLE;
            // Mostly legal counts, now and then zero or a count past the cap.
            if ($urandom_range(0, 9) != 0)
                r.cmd.clock_count = 6'($urandom_range(1, 32));
        end
        else if (pick >= 95)
            r.cmd.action = ACT_SPARE;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick >= idle_pct)
            return 0;
        if (pick < 4)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    task automatic send_cmd(step_row_t row);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmds_in_flight.push_back(row);
        cmd_valid <= 1'b1;
        cmd_item  <= row.cmd;
        do @(posedge clk); while (cmd_stall);
    endtask

    // Command intake and result check share one process so their order at an edge is fixed.
    always @(posedge clk)
    begin : watch
        step_row_t sent;
        bit_item_t want;
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            sent = cmds_in_flight.pop_front();
            predict_run(cmd_item);
            cmds_taken++;
            if (sent.typed)
            begin
                for (int k = 0; k < int'(sent.runlen); k++)
                    expected_bits.push_back('{tms_bit: sent.tms,
                                              tap_after: sent.taps[23 - 4 * k -: 4],
                                              last: (k == int'(sent.runlen) - 1)});
            end
            else
            begin
                foreach (run_bits[k])
                    expected_bits.push_back(run_bits[k]);
            end
        end
        if (rst_n && bit_valid && !bit_stall)
        begin
            bits_checked++;
            if (expected_bits.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected bit item %p", $time, bit_item);
            end
            else
            begin
                want = expected_bits.pop_front();
                if (bit_item.tms_bit !== want.tms_bit)
                begin
                    mismatches++;
                    $display("%0t: tms_bit expected %0b got %0b", $time, want.tms_bit,
                             bit_item.tms_bit);
                end
                if (bit_item.tap_after !== want.tap_after)
                begin
                    mismatches++;
                    $display("%0t: tap_after expected %0d got %0d", $time, want.tap_after,
                             bit_item.tap_after);
                end
                if (bit_item.last !== want.last)
                begin
                    mismatches++;
                    $display("%0t: last expected %0b got %0b", $time, want.last,
                             bit_item.last);
                end
            end
        end
    end

    initial
    begin
        int unsigned stall_len;
        bit_stall <= 1'b0;
        @(posedge clk);
        wait (rst_n);
        forever
        begin
            stall_len = pick_gap();
            if (stall_len != 0)
            begin
                bit_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            bit_stall <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    end

    initial
    begin
        int unsigned sent_random;
        step_row_t   row;
        tap_now      = ST_RTI;
        idle_pct     = 35;
        cmds_taken   = 0;
        bits_checked = 0;
        mismatches   = 0;
        sent_random  = 0;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd_item  <= '0;
        script = '{
            // Already in run-test-idle after reset: nothing comes out.
            row_of(ACT_GOTO,  ST_RTI,      6'd0,  1'b1, 3'd0, 1'b0, 24'h000000),
            row_of(ACT_RESET, ST_TLR,      6'd0,  1'b1, 3'd6, 1'b1, 24'h290000),
            row_of(ACT_IDLE,  ST_TLR,      6'd3,  1'b1, 3'd3, 1'b1, 24'h000000),
            row_of(ACT_SPARE, ST_UPD_IR,   6'd63, 1'b1, 3'd0, 1'b0, 24'h000000),
            row_of(ACT_IDLE,  ST_UPD_IR,   6'd0,  1'b1, 3'd0, 1'b0, 24'h000000),
            row_of(ACT_GOTO,  ST_RTI,      6'd0,  1'b1, 3'd1, 1'b0, 24'h100000),
            row_of(ACT_GOTO,  ST_SHIFT_DR, 6'd0,  1'b0, 3'd0, 1'b0, 24'h0),
            row_of(ACT_IDLE,  ST_TLR,      6'd5,  1'b1, 3'd5, 1'b0, 24'h444440),
            row_of(ACT_GOTO,  ST_PAUSE_DR, 6'd0,  1'b0, 3'd0, 1'b0, 24'h0),
            row_of(ACT_GOTO,  ST_EXIT2_DR, 6'd0,  1'b0, 3'd0, 1'b0, 24'h0),
            row_of(ACT_GOTO,  ST_EXIT1_DR, 6'd0,  1'b0, 3'd0, 1'b0, 24'h0),
            row_of(ACT_GOTO,  ST_UPD_DR,   6'd0,  1'b0, 3'd0, 1'b0, 24'h0),
            row_of(ACT_GOTO,  ST_CAP_DR,   6'd0,  1'b0, 3'd0, 1'b0, 24'h0),
            row_of(ACT_GOTO,  ST_SHIFT_IR, 6'd0,  1'b0, 3'd0, 1'b0, 24'h0),
            row_of(ACT_GOTO,  ST_PAUSE_IR, 6'd0,  1'b0, 3'd0, 1'b0, 24'h0),
            row_of(ACT_GOTO,  ST_EXIT2_IR, 6'd0,  1'b0, 3'd0, 1'b0, 24'h0),
            row_of(ACT_GOTO,  ST_EXIT1_IR, 6'd0,  1'b0, 3'd0, 1'b0, 24'h0),
            row_of(ACT_GOTO,  ST_UPD_IR,   6'd0,  1'b0, 3'd0, 1'b0, 24'h0),
            row_of(ACT_GOTO,  ST_CAP_IR,   6'd0,  1'b0, 3'd0, 1'b0, 24'h0),
            row_of(ACT_GOTO,  ST_SEL_IR,   6'd0,  1'b0, 3'd0, 1'b0, 24'h0),
            row_of(ACT_GOTO,  ST_SEL_DR,   6'd0,  1'b0, 3'd0, 1'b0, 24'h0),
            // Idling in select-DR moves the controller on to capture-DR.
            row_of(ACT_IDLE,  ST_SEL_DR,   6'd1,  1'b0, 3'd0, 1'b0, 24'h0),
            row_of(ACT_GOTO,  ST_TLR,      6'd0,  1'b0, 3'd0, 1'b0, 24'h0),
            // A count past the cap gives a full run of ones in test-logic-reset.
            row_of(ACT_IDLE,  ST_TLR,      6'd63, 1'b0, 3'd0, 1'b0, 24'h0),
            row_of(ACT_GOTO,  ST_EXIT2_DR, 6'd0,  1'b0, 3'd0, 1'b0, 24'h0),
            row_of(ACT_RESET, ST_UPD_IR,   6'd63, 1'b0, 3'd0, 1'b0, 24'h0)
        };
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (script[i])
            send_cmd(script[i]);
        while (sent_random < RANDOM_ITEMS)
        begin
            // One stretch runs back to back on both sides.
            idle_pct = (sent_random >= 200 && sent_random < 260) ? 0 : 35;
            row = random_row();
            sent_random++;
            send_cmd(row);
        end
        cmd_valid <= 1'b0;
        idle_pct  = 0;
        while (expected_bits.size() != 0 || cmds_in_flight.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d commands (directed and random goto, reset, idle, spare) taken",
                 cmds_taken);
        $display("tb: %0d TMS bit items checked, %0d mismatches", bits_checked, mismatches);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("tb: timeout with %0d bit items still expected", expected_bits.size());
        $display("tb: done, errors");
        $finish;
    end

endmodule
